@@ hw/rtl/nco_pkg.sv @@
// Shared types, field widths and constants for the NCO sine generator.
// Also holds the elaboration-time builder for the quarter-wave sine table.
// No dependencies.
package nco_pkg;

  localparam int FREQ_W     = 36;
  localparam int GAIN_W     = 48;
  localparam int AMP_W      = 24;
  localparam int BIAS_W     = 24;
  localparam int START_W    = 32;
  localparam int RUN_W      = 25;
  localparam int CNT_W      = 24;
  localparam int TBL_W      = 16;
  localparam int PROD_W     = 64;   // phase step product kept modulo 2^64
  localparam int HALF_W     = AMP_W + TBL_W + 1;
  localparam int VAL_W      = 34;   // bias plus half amplitude, before clamping
  localparam int IN_TDATA_W = ((FREQ_W + 7) / 8) * 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [RUN_W-1:0]  MAX_RUN     = RUN_W'(25'd16777216);
  localparam logic [63:0]       PI_Q30      = 64'd3373259426;

  localparam logic [GAIN_W-1:0] GAIN_RESET  = GAIN_W'(48'd2814749);
  localparam logic [AMP_W-1:0]  AMP_RESET   = AMP_W'(24'd2);
  localparam logic [RUN_W-1:0]  RUN_RESET   = RUN_W'(25'd100000);
  localparam logic [FREQ_W-1:0] FREQ_RESET  = FREQ_W'(36'd1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_GAIN   = 3'd0,
    CFG_AMPLITUDE   = 3'd1,
    CFG_BIAS        = 3'd2,
    CFG_START_PHASE = 3'd3,
    CFG_RUN_LENGTH  = 3'd4
  } cfg_reg_t;

  // Entry k of the quarter-wave table: round(65535 * sin(pi/2 * (2k+1) / 2^(bits+1)))
  // from a Q30 Taylor series to x^11, each term truncated.
  function automatic logic [TBL_W-1:0] sine_entry(input int unsigned k,
                                                  input int unsigned addr_bits);
    logic [63:0]    a;
    logic [63:0]    term;
    logic [63:0]    v;
    longint signed  sum;
    a    = (64'(2 * k + 1) * PI_Q30) >> (addr_bits + 2);
    term = a;
    sum  = signed'(a);
    term = (((term * a) >> 30) * a) >> 30;
    term = term / 64'd6;
    sum  = sum - signed'(term);
    term = (((term * a) >> 30) * a) >> 30;
    term = term / 64'd20;
    sum  = sum + signed'(term);
    term = (((term * a) >> 30) * a) >> 30;
    term = term / 64'd42;
    sum  = sum - signed'(term);
    term = (((term * a) >> 30) * a) >> 30;
    term = term / 64'd72;
    sum  = sum + signed'(term);
    term = (((term * a) >> 30) * a) >> 30;
    term = term / 64'd110;
    sum  = sum - signed'(term);
    if (sum < 0) begin
      sum = 0;
    end
    v = (unsigned'(sum) * 64'd65535 + (64'd1 << 29)) >> 30;
    if (v > 64'd65535) begin
      v = 64'd65535;
    end
    return v[TBL_W-1:0];
  endfunction

endpackage

@@ hw/rtl/nco_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module nco_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/nco_sine_generator.sv @@
// NCO sine generator: one sample word out per word in; its valid moves through s1_v to s6_v into m_tvalid.
// Throughput one word per cycle unless a full output is stalled by m_tready; the phase add and run counter are loops.
// The frequency-times-gain product is split into 18x24 partial products over three stages.
// Synchronous reset; afterwards all 2^TABLE_ADDR_BITS entries of the sine table RAM are loaded,
// during which s_tready stays low (configuration writes are still taken).
// Depends on nco_pkg and nco_ram.
module nco_sine_generator #(
  parameter int PHASE_BITS      = 32,
  parameter int TABLE_ADDR_BITS = 10,
  parameter int SAMPLE_BITS     = 24
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration write channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [nco_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [nco_pkg::CFG_DATA_W-1:0]         cfg_data,
  // input words
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [nco_pkg::IN_TDATA_W-1:0]         s_tdata,  // [35:0] freq_hz, rest zero
  input  logic                                   s_tuser,  // [0] freq_update
  // output words
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] m_tdata,  // sample, zero-filled above
  output logic                                   m_tlast
);
  import nco_pkg::*;

  localparam int TBL_N = 1 << TABLE_ADDR_BITS;
  localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam logic signed [VAL_W-1:0] SAT_HI =
    VAL_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [VAL_W-1:0] SAT_LO = -SAT_HI - VAL_W'(1);

  // configuration registers
  logic [GAIN_W-1:0]  step_gain;
  logic [AMP_W-1:0]   amplitude;
  logic [BIAS_W-1:0]  bias;
  logic [START_W-1:0] start_phase;
  logic [RUN_W-1:0]   run_length;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_gain   <= GAIN_RESET;
      amplitude   <= AMP_RESET;
      bias        <= '0;
      start_phase <= '0;
      run_length  <= RUN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_STEP_GAIN:   step_gain   <= cfg_data[GAIN_W-1:0];
        CFG_AMPLITUDE:   amplitude   <= cfg_data[AMP_W-1:0];
        CFG_BIAS:        bias        <= cfg_data[BIAS_W-1:0];
        CFG_START_PHASE: start_phase <= cfg_data[START_W-1:0];
        CFG_RUN_LENGTH:  run_length  <= cfg_data[RUN_W-1:0];
        default: ;
      endcase
    end
  end

  // sine table load after reset
  logic [TBL_W-1:0]           sine_rom [TBL_N];
  logic [TABLE_ADDR_BITS-1:0] fill_addr;
  logic                       fill_done;

  for (genvar k = 0; k < TBL_N; k++) begin : g_rom
    assign sine_rom[k] = sine_entry(k, TABLE_ADDR_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_addr <= '0;
      fill_done <= 1'b0;
    end else if (!fill_done) begin
      fill_addr <= fill_addr + 1'b1;
      if (fill_addr == TABLE_ADDR_BITS'(TBL_N - 1)) begin
        fill_done <= 1'b1;
      end
    end
  end

  // whole pipe moves when the output register is free or being drained
  logic adv;
  logic accept;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv && fill_done;
  assign accept   = s_tvalid && s_tready;

  // stage 1: frequency selection
  logic [FREQ_W-1:0] current_freq;
  logic [FREQ_W-1:0] freq_sel;
  logic [FREQ_W-1:0] s1_freq;
  logic              s1_v;

  assign freq_sel = s_tuser ? s_tdata[FREQ_W-1:0] : current_freq;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_freq <= FREQ_RESET;
    end else if (accept) begin
      current_freq <= freq_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_freq <= freq_sel;
    end
  end

  // stage 2: partial products, freq split 18/18, gain split 24/24
  logic [41:0] s2_ll, s2_lh, s2_hl, s2_hh;
  logic        s2_v;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ll <= 42'(s1_freq[17:0])  * 42'(step_gain[23:0]);
      s2_lh <= 42'(s1_freq[17:0])  * 42'(step_gain[47:24]);
      s2_hl <= 42'(s1_freq[35:18]) * 42'(step_gain[23:0]);
      s2_hh <= 42'(s1_freq[35:18]) * 42'(step_gain[47:24]);
    end
  end

  // stage 3: pair sums
  logic [PROD_W-1:0] s3_lo, s3_hi;
  logic              s3_v;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_lo <= PROD_W'(s2_ll) + (PROD_W'(s2_lh) << 24);
      s3_hi <= PROD_W'(s2_hl) + (PROD_W'(s2_hh) << 24);
    end
  end

  // stage 4: phase step, product modulo 2^64 then >> 16
  logic [PROD_W-1:0]     prod_full;
  logic [PHASE_BITS-1:0] s4_step;
  logic                  s4_v;

  assign prod_full = s3_lo + (s3_hi << 18);

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_step <= prod_full[PHASE_BITS+15:16];
    end
  end

  // stage 5: phase accumulator and run counter, table read issued from the phase
  logic [PHASE_BITS-1:0]      phase_acc;
  logic [CNT_W-1:0]           sample_count;
  logic [RUN_W-1:0]           run_len;
  logic                       is_last;
  logic [PHASE_BITS+31:0]     start_wide;
  logic [PHASE_BITS-1:0]      start_al;
  logic [1:0]                 quad;
  logic [TABLE_ADDR_BITS-1:0] tbl_idx;
  logic [TBL_W-1:0]           tbl_data;
  logic                       s5_v, s5_neg, s5_last;

  assign start_wide = {start_phase, {PHASE_BITS{1'b0}}};
  assign start_al   = start_wide[PHASE_BITS+31:32];

  always_comb begin
    if (run_length == '0) begin
      run_len = RUN_W'(1);
    end else if (run_length > MAX_RUN) begin
      run_len = MAX_RUN;
    end else begin
      run_len = run_length;
    end
  end

  assign is_last = (RUN_W'(sample_count) + RUN_W'(1)) >= run_len;
  assign quad    = phase_acc[PHASE_BITS-1 -: 2];
  // odd quadrants run the table backwards
  assign tbl_idx = quad[0] ? ~phase_acc[PHASE_BITS-3 -: TABLE_ADDR_BITS]
                           :  phase_acc[PHASE_BITS-3 -: TABLE_ADDR_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc    <= '0;
      sample_count <= '0;
    end else if (adv && s4_v) begin
      if (is_last) begin
        phase_acc    <= start_al;
        sample_count <= '0;
      end else begin
        phase_acc    <= phase_acc + s4_step;
        sample_count <= sample_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_neg  <= quad[1];
      s5_last <= is_last;
    end
  end

  nco_ram #(
    .WIDTH (TBL_W),
    .DEPTH (TBL_N)
  ) u_sine_ram (
    .clk     (clk),
    .wr_en   (!fill_done),
    .wr_addr (fill_addr),
    .wr_data (sine_rom[fill_addr]),
    .rd_en   (adv),
    .rd_addr (tbl_idx),
    .rd_data (tbl_data)
  );

  // stage 6: amplitude scaling
  logic [AMP_W+TBL_W-1:0] s6_prod;
  logic                   s6_v, s6_neg, s6_last;

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_prod <= (AMP_W + TBL_W)'(amplitude) * (AMP_W + TBL_W)'(tbl_data);
      s6_neg  <= s5_neg;
      s6_last <= s5_last;
    end
  end

  // stage 7: round, apply sign, add bias, clamp
  logic [HALF_W-1:0]         half_rnd;
  logic [AMP_W-1:0]          half_mag;
  logic signed [VAL_W-1:0]   val;
  logic signed [VAL_W-1:0]   val_sat;
  logic [SAMPLE_BITS-1:0]    sample_bits;

  // halves round away from zero since rounding is done on the magnitude
  assign half_rnd = HALF_W'(s6_prod) + HALF_W'(17'h10000);
  assign half_mag = half_rnd[HALF_W-1:17];

  always_comb begin
    if (s6_neg) begin
      val = VAL_W'(signed'(bias)) - signed'(VAL_W'(half_mag));
    end else begin
      val = VAL_W'(signed'(bias)) + signed'(VAL_W'(half_mag));
    end
    if (val > SAT_HI) begin
      val_sat = SAT_HI;
    end else if (val < SAT_LO) begin
      val_sat = SAT_LO;
    end else begin
      val_sat = val;
    end
  end

  assign sample_bits = val_sat[SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= OUT_W'(sample_bits);
      m_tlast <= s6_last;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v     <= 1'b0;
      s2_v     <= 1'b0;
      s3_v     <= 1'b0;
      s4_v     <= 1'b0;
      s5_v     <= 1'b0;
      s6_v     <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      s1_v     <= accept;
      s2_v     <= s1_v;
      s3_v     <= s2_v;
      s4_v     <= s3_v;
      s5_v     <= s4_v;
      s6_v     <= s5_v;
      m_tvalid <= s6_v;
    end
  end

endmodule
